// ----- sv/dqtg_pkg.sv -----
// ----------------------------------------------------------------------------
// dqtg_pkg
// Shared types, constants and the quarter-wave table function of the
// dual quadrature tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dqtg_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int STEP_BITS      = 32;
    localparam int AMP_BITS       = 16;
    localparam int AMP_FRAC_BITS  = 15;

    localparam logic [AMP_BITS-1:0]  AMP_ONE    = 16'd32768;
    localparam logic [AMP_BITS-1:0]  AMP_RESET  = 16'd16384;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 32'd39370534;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_STEP_LEFT  = 3'd0,
        REG_STEP_RIGHT = 3'd1,
        REG_AMPLITUDE  = 3'd2,
        REG_MIX_ENABLE = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [STEP_BITS-1:0] step_left;
        logic [STEP_BITS-1:0] step_right;
        logic [AMP_BITS-1:0]  amplitude;
        logic                 mix_enable;
    } tone_cfg_t;

    // Entry k of the quarter-wave table: full scale times the sine at the
    // middle of bin k, by a Q30 Taylor series up to x^15. Elaboration only.
    function automatic logic [63:0] quarter_entry(input int k, input int addr_bits,
                                                  input int sample_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] full_scale;
        logic [63:0] prod;
        longint      s;
        x    = (HALF_PI_Q30 * 64'(2 * k + 1)) >> (addr_bits + 1);
        x2   = (x * x) >> 30;
        s    = longint'(x);
        term = ((x * x2) >> 30) / 64'd6;
        s    = s - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        s    = s + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        s    = s - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        s    = s + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        s    = s - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        s    = s + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        s    = s - longint'(term);
        if (s < 0) begin
            s = 0;
        end
        full_scale = (64'd1 << (sample_bits - 1)) - 64'd1;
        prod       = 64'(s) * full_scale + (64'd1 << 29);
        return prod >> 30;
    endfunction

endpackage

`default_nettype wire

// ----- sv/dqtg_sine_rom.sv -----
// ----------------------------------------------------------------------------
// dqtg_sine_rom
// Quarter-wave sine ROM with two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module dqtg_sine_rom
    import dqtg_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       rd_en,
    input  wire logic [TABLE_ADDR_BITS-1:0] addr_a,
    input  wire logic [TABLE_ADDR_BITS-1:0] addr_b,
    output logic      [SAMPLE_BITS-2:0]     data_a_reg,
    output logic      [SAMPLE_BITS-2:0]     data_b_reg
);

    localparam int DEPTH    = 1 << TABLE_ADDR_BITS;
    localparam int MAG_BITS = SAMPLE_BITS - 1;

    logic [MAG_BITS-1:0] rom_tbl [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_entry
        localparam logic [63:0] ENTRY = quarter_entry(k, TABLE_ADDR_BITS, SAMPLE_BITS);
        assign rom_tbl[k] = ENTRY[MAG_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_a_reg <= rom_tbl[addr_a];
            data_b_reg <= rom_tbl[addr_b];
        end
    end

endmodule

`default_nettype wire

// ----- sv/dqtg_phase_gen.sv -----
// ----------------------------------------------------------------------------
// dqtg_phase_gen
// Two phase accumulators and the quadrant folding into table addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module dqtg_phase_gen
    import dqtg_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       advance,
    input  wire logic [STEP_BITS-1:0]       step_left,
    input  wire logic [STEP_BITS-1:0]       step_right,
    output logic      [TABLE_ADDR_BITS-1:0] addr_left,
    output logic      [TABLE_ADDR_BITS-1:0] addr_right,
    output logic                            neg_left,
    output logic                            neg_right
);

    logic [PHASE_BITS-1:0]      phase_left_reg;
    logic [PHASE_BITS-1:0]      phase_right_reg;
    logic [PHASE_BITS-1:0]      phase_left_next;
    logic [PHASE_BITS-1:0]      phase_right_next;
    logic [1:0]                 quad_left;
    logic [1:0]                 quad_right;
    logic [TABLE_ADDR_BITS-1:0] idx_left;
    logic [TABLE_ADDR_BITS-1:0] idx_right;

    assign phase_left_next  = phase_left_reg + PHASE_BITS'(step_left);
    assign phase_right_next = phase_right_reg + PHASE_BITS'(step_right);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_left_reg  <= '0;
            phase_right_reg <= '0;
        end else if (advance) begin
            phase_left_reg  <= phase_left_next;
            phase_right_reg <= phase_right_next;
        end
    end

    // cosine: shift the right phase a quarter turn, i.e. bump the quadrant
    assign quad_left  = phase_left_reg[PHASE_BITS-1 -: 2];
    assign quad_right = phase_right_reg[PHASE_BITS-1 -: 2] + 2'd1;
    assign idx_left   = phase_left_reg[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign idx_right  = phase_right_reg[PHASE_BITS-3 -: TABLE_ADDR_BITS];

    // odd quadrants run the table backwards, upper half negates
    assign addr_left  = quad_left[0] ? ~idx_left : idx_left;
    assign addr_right = quad_right[0] ? ~idx_right : idx_right;
    assign neg_left   = quad_left[1];
    assign neg_right  = quad_right[1];

`ifndef SYNTHESIS
    a_hold_left: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(phase_left_reg))
        else $error("left phase moved without a transfer");
    a_step_left: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> phase_left_reg == $past(phase_left_next))
        else $error("left phase did not advance by its step");
    a_step_right: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> phase_right_reg == $past(phase_right_next))
        else $error("right phase did not advance by its step");
`endif

endmodule

`default_nettype wire

// ----- sv/dqtg_mixer.sv -----
// ----------------------------------------------------------------------------
// dqtg_mixer
// Scales a table magnitude by the amplitude, applies the sign, and either
// replaces the incoming sample or adds to it with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module dqtg_mixer
    import dqtg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                          mag_neg,
    input  wire logic        [SAMPLE_BITS-2:0] mag,
    input  wire logic        [AMP_BITS-1:0]    amplitude,
    input  wire logic                          mix_enable,
    input  wire logic signed [SAMPLE_BITS-1:0] incoming,
    output logic signed      [SAMPLE_BITS-1:0] sample
);

    localparam int MAG_BITS  = SAMPLE_BITS - 1;
    localparam int PROD_BITS = MAG_BITS + AMP_BITS + 1;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (AMP_FRAC_BITS - 1);

    logic [AMP_BITS-1:0]              amp_sat;
    logic [PROD_BITS-1:0]             prod;
    logic [MAG_BITS-1:0]              scaled;
    logic signed [SAMPLE_BITS-1:0]    tone;
    logic signed [SAMPLE_BITS:0]      sum;

    // gain above one clips to one
    assign amp_sat = (amplitude > AMP_ONE) ? AMP_ONE : amplitude;
    assign prod    = PROD_BITS'(mag) * PROD_BITS'(amp_sat) + ROUND_HALF;
    assign scaled  = prod[AMP_FRAC_BITS +: MAG_BITS];
    assign tone    = mag_neg ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});
    assign sum     = {incoming[SAMPLE_BITS-1], incoming} + {tone[SAMPLE_BITS-1], tone};

    always_comb begin
        if (!mix_enable) begin
            sample = tone;
        end else if (sum[SAMPLE_BITS] != sum[SAMPLE_BITS-1]) begin
            sample = sum[SAMPLE_BITS] ? SMP_MIN : SMP_MAX;
        end else begin
            sample = sum[SAMPLE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- sv/dual_quadrature_tone_generator_top.sv -----
// ----------------------------------------------------------------------------
// dual_quadrature_tone_generator_top
// Two-channel DDS tone generator: sine on the left, cosine on the right.
// ----------------------------------------------------------------------------
// Takes one stereo frame per clock when the output side is not stalled and
// returns one result frame for each, after the stage 1 registers and the
// output register; stage 1 reads the quarter-wave ROM (2^TABLE_ADDR_BITS
// entries, one read port per channel), stage 2 scales by the amplitude,
// mixes or replaces, and loads the output register. s_ready follows
// m_ready combinationally through the two-stage pipeline. Configuration
// writes are always taken (cfg_ready is tied high) and should only be
// issued while no frame is in flight; unknown register indexes are
// dropped. Phases start at zero after reset and run on continuously
// across blocks; block_end travels with its frame.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_quadrature_tone_generator_top
    import dqtg_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic        [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic        [CFG_DATA_BITS-1:0]  cfg_data,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_incoming_left,
    input  wire logic signed [SAMPLE_BITS-1:0] s_incoming_right,
    input  wire logic                          s_block_end_in,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed      [SAMPLE_BITS-1:0] m_sample_left,
    output logic signed      [SAMPLE_BITS-1:0] m_sample_right,
    output logic                               m_block_end_out
);

    localparam int MAG_BITS = SAMPLE_BITS - 1;

    // configuration
    tone_cfg_t cfg_reg;

    // pipeline control
    logic s_xfer;
    logic out_free;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic m_valid_reg;
    logic m_valid_next;

    // stage 1 payload (ROM data registered inside the ROM)
    logic signed [SAMPLE_BITS-1:0] s1_in_left_reg;
    logic signed [SAMPLE_BITS-1:0] s1_in_right_reg;
    logic                          s1_end_reg;
    logic                          s1_neg_left_reg;
    logic                          s1_neg_right_reg;
    logic [MAG_BITS-1:0]           rom_left;
    logic [MAG_BITS-1:0]           rom_right;

    // phase generator outputs
    logic [TABLE_ADDR_BITS-1:0] addr_left;
    logic [TABLE_ADDR_BITS-1:0] addr_right;
    logic                       neg_left;
    logic                       neg_right;

    // result
    logic signed [SAMPLE_BITS-1:0] mix_left;
    logic signed [SAMPLE_BITS-1:0] mix_right;
    logic signed [SAMPLE_BITS-1:0] m_sample_left_reg;
    logic signed [SAMPLE_BITS-1:0] m_sample_right_reg;
    logic                          m_block_end_reg;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_left  <= STEP_RESET;
            cfg_reg.step_right <= STEP_RESET;
            cfg_reg.amplitude  <= AMP_RESET;
            cfg_reg.mix_enable <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_STEP_LEFT: begin
                    cfg_reg.step_left <= cfg_data[STEP_BITS-1:0];
                end
                REG_STEP_RIGHT: begin
                    cfg_reg.step_right <= cfg_data[STEP_BITS-1:0];
                end
                REG_AMPLITUDE: begin
                    cfg_reg.amplitude <= cfg_data[AMP_BITS-1:0];
                end
                REG_MIX_ENABLE: begin
                    cfg_reg.mix_enable <= cfg_data[0];
                end
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    // ------------------------------------------------------- pipeline control
    // The output register frees up when empty or taken; stage 1 can load
    // whenever it is empty or moving on into the output register.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || out_free;
    assign s_xfer   = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        m_valid_next  = m_valid_reg;
        if (s_ready) begin
            s1_valid_next = s_valid;
        end
        if (out_free) begin
            m_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // ---------------------------------------------------------------- stage 1
    dqtg_phase_gen #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_phase_gen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (s_xfer),
        .step_left  (cfg_reg.step_left),
        .step_right (cfg_reg.step_right),
        .addr_left  (addr_left),
        .addr_right (addr_right),
        .neg_left   (neg_left),
        .neg_right  (neg_right)
    );

    // ROM output register is the stage 1 data; load only on a transfer
    dqtg_sine_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_sine_rom (
        .aclk       (aclk),
        .rd_en      (s_xfer),
        .addr_a     (addr_left),
        .addr_b     (addr_right),
        .data_a_reg (rom_left),
        .data_b_reg (rom_right)
    );

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_in_left_reg   <= s_incoming_left;
            s1_in_right_reg  <= s_incoming_right;
            s1_end_reg       <= s_block_end_in;
            s1_neg_left_reg  <= neg_left;
            s1_neg_right_reg <= neg_right;
        end
    end

    // ---------------------------------------------------------------- stage 2
    dqtg_mixer #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mixer_left (
        .mag_neg    (s1_neg_left_reg),
        .mag        (rom_left),
        .amplitude  (cfg_reg.amplitude),
        .mix_enable (cfg_reg.mix_enable),
        .incoming   (s1_in_left_reg),
        .sample     (mix_left)
    );

    dqtg_mixer #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mixer_right (
        .mag_neg    (s1_neg_right_reg),
        .mag        (rom_right),
        .amplitude  (cfg_reg.amplitude),
        .mix_enable (cfg_reg.mix_enable),
        .incoming   (s1_in_right_reg),
        .sample     (mix_right)
    );

    // hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (out_free && s1_valid_reg) begin
            m_sample_left_reg  <= mix_left;
            m_sample_right_reg <= mix_right;
            m_block_end_reg    <= s1_end_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sample_left   = m_sample_left_reg;
    assign m_sample_right  = m_sample_right_reg;
    assign m_block_end_out = m_block_end_reg;

`ifndef SYNTHESIS
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s1_valid_reg && !m_valid_reg) |-> s_ready)
        else $error("empty pipeline refuses input");
    a_stage1_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_free) |=> m_valid_reg)
        else $error("stage 1 frame lost on its way to the output");
    a_stage1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(rom_left)
                                         && $stable(s1_in_left_reg)))
        else $error("stalled stage 1 frame changed");
`endif

endmodule

`default_nettype wire
